### hdl/blm_pkg.sv
// Shared types and constants for the battery level monitor.
package blm_pkg;

    localparam int VOLT_W    = 16;
    localparam int PCT_W     = 7;
    localparam int LVL_W     = 3;
    localparam int FAIL_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_N     = 24;
    localparam int DIV_M     = 16;
    localparam int DIV_CW    = $clog2(DIV_N + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA   = 2'd2;

    localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST = 16'd0;
    localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST = 16'd65535;
    localparam logic [VOLT_W-1:0] MAX_DELTA_RST   = 16'd100;

    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [FAIL_W-1:0] FAIL_MAX   = 4'd15;
    localparam logic [FAIL_W-1:0] FAIL_LIMIT = 4'd10;

    localparam logic [LVL_W-1:0] LVL_SUPPLY = 3'd0;
    localparam logic [LVL_W-1:0] LVL_FULL   = 3'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_MID    = 3'd3;
    localparam logic [LVL_W-1:0] LVL_LOW    = 3'd4;
    localparam logic [LVL_W-1:0] LVL_EMPTY  = 3'd5;

    typedef struct packed {
        logic              read_ok;
        logic [VOLT_W-1:0] ext_voltage;
        logic [VOLT_W-1:0] int_voltage;
        logic              drain_external;
        logic              on_supply;
    } blm_tick_t;

    typedef struct packed {
        logic              updated;
        logic [LVL_W-1:0]  level_code;
        logic [PCT_W-1:0]  ext_percent;
        logic [PCT_W-1:0]  int_percent;
        logic [VOLT_W-1:0] ext_level;
        logic [VOLT_W-1:0] int_level;
        logic              manager_present;
    } blm_result_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] ext_sum;
        logic [DIV_N-1:0] int_sum;
        logic [DIV_M-1:0] ext_cnt;
        logic [DIV_M-1:0] int_cnt;
    } blm_ring_st_t;

endpackage

### hdl/blm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module blm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/blm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module blm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [blm_pkg::DIV_N-1:0] dividend,
    input  logic [blm_pkg::DIV_M-1:0] divisor,
    output logic                      busy,
    output logic [blm_pkg::DIV_N-1:0] quotient
);
    import blm_pkg::*;

    logic              busy_reg, busy_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_N-1:0]  quo_reg, quo_next;
    logic [DIV_M-1:0]  rem_reg, rem_next;
    logic [DIV_M-1:0]  dsr_reg, dsr_next;
    logic [DIV_M:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIV_N-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_N);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIV_M'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_M-1:0];
                quo_next = {quo_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### hdl/blm_ring.sv
// Sample rings in RAM with per-entry valid bits and a sum/count sweep.
module blm_ring #(
    parameter int SAMPLE_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [blm_pkg::VOLT_W-1:0]  ext_sample,
    input  logic [blm_pkg::VOLT_W-1:0]  int_sample,
    output blm_pkg::blm_ring_st_t       status
);
    import blm_pkg::*;

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(SAMPLE_DEPTH - 1);

    logic [AW-1:0]           head_reg, head_next;
    logic [SAMPLE_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic                    issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic                    ent_vld_reg, ent_vld_next;
    logic                    done_reg, done_next;
    logic [DIV_N-1:0]        ext_sum_reg, ext_sum_next;
    logic [DIV_N-1:0]        int_sum_reg, int_sum_next;
    logic [DIV_M-1:0]        ext_cnt_reg, ext_cnt_next;
    logic [DIV_M-1:0]        int_cnt_reg, int_cnt_next;
    logic [2*VOLT_W-1:0]     rdata;
    logic [VOLT_W-1:0]       rd_ext;
    logic [VOLT_W-1:0]       rd_int;

    blm_ram #(
        .WIDTH (2 * VOLT_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (head_reg),
        .wdata ({ext_sample, int_sample}),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    assign rd_ext = rdata[2*VOLT_W-1:VOLT_W];
    assign rd_int = rdata[VOLT_W-1:0];

    always_comb
    begin
        head_next    = head_reg;
        valid_next   = valid_reg;
        rd_ptr_next  = rd_ptr_reg;
        issue_next   = issue_reg;
        pend_next    = pend_reg;
        ent_vld_next = ent_vld_reg;
        done_next    = done_reg;
        ext_sum_next = ext_sum_reg;
        int_sum_next = int_sum_reg;
        ext_cnt_next = ext_cnt_reg;
        int_cnt_next = int_cnt_reg;
        if (push)
        begin
            head_next           = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            valid_next[head_reg] = 1'b1;
            rd_ptr_next         = '0;
            issue_next          = 1'b1;
            pend_next           = 1'b0;
            done_next           = 1'b0;
            ext_sum_next        = '0;
            int_sum_next        = '0;
            ext_cnt_next        = '0;
            int_cnt_next        = '0;
        end
        else
        begin
            pend_next    = issue_reg;
            ent_vld_next = valid_reg[rd_ptr_reg];
            if (issue_reg)
            begin
                if (rd_ptr_reg == LAST)
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end
            if (pend_reg)
            begin
                if (ent_vld_reg && (rd_ext != '0))
                begin
                    ext_sum_next = ext_sum_reg + DIV_N'(rd_ext);
                    ext_cnt_next = ext_cnt_reg + 1'b1;
                end
                if (ent_vld_reg && (rd_int != '0))
                begin
                    int_sum_next = int_sum_reg + DIV_N'(rd_int);
                    int_cnt_next = int_cnt_reg + 1'b1;
                end
                if (!issue_reg)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            valid_reg   <= '0;
            rd_ptr_reg  <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            ent_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            ext_sum_reg <= '0;
            int_sum_reg <= '0;
            ext_cnt_reg <= '0;
            int_cnt_reg <= '0;
        end
        else
        begin
            head_reg    <= head_next;
            valid_reg   <= valid_next;
            rd_ptr_reg  <= rd_ptr_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            ent_vld_reg <= ent_vld_next;
            done_reg    <= done_next;
            ext_sum_reg <= ext_sum_next;
            int_sum_reg <= int_sum_next;
            ext_cnt_reg <= ext_cnt_next;
            int_cnt_reg <= int_cnt_next;
        end
    end

    assign status.done    = done_reg;
    assign status.ext_sum = ext_sum_reg;
    assign status.int_sum = int_sum_reg;
    assign status.ext_cnt = ext_cnt_reg;
    assign status.int_cnt = int_cnt_reg;

endmodule

### hdl/battery_level_monitor_top.sv
// Battery level monitor: tick channel in, result channel out, register write port.
//
// Each request on the tick channel produces exactly one request on the result
// channel. Only every (READ_PERIOD+1)-th tick acts; the others return the held
// values with updated low, as does an acting tick whose read failed.
// A non-acting or failed tick goes straight to the emit step, which loads the result
// register; the next tick is accepted once the block is idle again.
// A good read passes through the sweep, mean, level and emit steps before it
// loads the register: the ring RAM is swept one entry a cycle while two 24-bit
// serial dividers form the percentages, then the same dividers form the two ring
// means one quotient bit per cycle.
// One tick is worked on at a time; tick_stall is high while it is in flight.
// A finished result sits in the output register; the next tick is accepted
// while it waits. With result_stall high the result holds and a further
// result waits in the block until the register frees.
// Registers are written through cfg_valid/cfg_ready (always ready) and must
// only change while the block is idle. Unknown indexes are ignored.
// Reset clears all held values, counters and ring valid bits and restores the
// register defaults; no clearing pass is needed.
module battery_level_monitor_top #(
    parameter int SAMPLE_DEPTH  = 16,
    parameter int LEVEL_DIVISOR = 4,
    parameter int READ_PERIOD   = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick_valid,
    output logic                           tick_stall,
    input  blm_pkg::blm_tick_t             tick,
    output logic                           result_valid,
    input  logic                           result_stall,
    output blm_pkg::blm_result_t           result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blm_pkg::VOLT_W-1:0]     cfg_data
);
    import blm_pkg::*;

    localparam int TICK_W    = $clog2(READ_PERIOD + 1);
    localparam int LVL_SHIFT = VOLT_W + $clog2(LEVEL_DIVISOR);
    localparam int RECIP_W   = LVL_SHIFT + 1;
    localparam int PROD_W    = VOLT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] LVL_RECIP =
        RECIP_W'(((64'd1 << LVL_SHIFT) + 64'(LEVEL_DIVISOR) - 64'd1) / 64'(LEVEL_DIVISOR));

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,
        ST_MEAN  = 5'b00100,
        ST_LEVEL = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    function automatic logic [VOLT_W-1:0] clamp_volt(
        input logic [VOLT_W-1:0] v,
        input logic [VOLT_W-1:0] lo,
        input logic [VOLT_W-1:0] hi
    );
        logic [VOLT_W-1:0] t;
        t = (v > hi) ? hi : v;
        if (t < lo)
        begin
            t = lo;
        end
        return t;
    endfunction

    function automatic logic [PCT_W-1:0] pct_fix(
        input logic             zero,
        input logic [DIV_N-1:0] q
    );
        logic [PCT_W-1:0] p;
        if (zero)
        begin
            p = '0;
        end
        else if (q > DIV_N'(PCT_FULL))
        begin
            p = PCT_FULL;
        end
        else
        begin
            p = q[PCT_W-1:0];
        end
        return p;
    endfunction

    function automatic logic [VOLT_W-1:0] follow_mean(
        input logic [VOLT_W-1:0] held,
        input logic [VOLT_W-1:0] mean,
        input logic [VOLT_W-1:0] lim
    );
        logic [VOLT_W-1:0] absd;
        absd = (held > mean) ? (held - mean) : (mean - held);
        return (absd > lim) ? mean : held;
    endfunction

    state_t            state_reg, state_next;
    logic [TICK_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [FAIL_W-1:0] fail_cnt_reg, fail_cnt_next;
    logic              present_reg, present_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [PCT_W-1:0]  ext_pct_reg, ext_pct_next;
    logic [PCT_W-1:0]  int_pct_reg, int_pct_next;
    logic [VOLT_W-1:0] ext_held_reg, ext_held_next;
    logic [VOLT_W-1:0] int_held_reg, int_held_next;
    logic [VOLT_W-1:0] min_reg, min_next;
    logic [VOLT_W-1:0] max_reg, max_next;
    logic [VOLT_W-1:0] delta_reg, delta_next;
    logic              upd_reg, upd_next;
    logic              result_valid_reg, result_valid_next;

    logic              drain_reg, drain_next;
    logic              supply_reg, supply_next;
    logic [7:0]        interval_reg, interval_next;
    logic              ext_pz_reg, ext_pz_next;
    logic              int_pz_reg, int_pz_next;
    blm_result_t       result_reg, result_next;

    logic              tick_acc;
    logic              acting;
    logic              good;
    logic [FAIL_W-1:0] fail_inc;
    logic [VOLT_W-1:0] ext_clamped;
    logic [VOLT_W-1:0] int_clamped;
    logic [VOLT_W-1:0] ext_off;
    logic [VOLT_W-1:0] int_off;
    logic              range_bad;
    logic              span_neg;
    logic [VOLT_W-1:0] span_mag;
    logic [PROD_W-1:0] span_prod;
    logic [7:0]        iv_mag;
    logic              sweep_done;
    logic              mean_done;
    logic              div_start;
    logic [DIV_N-1:0]  ext_dvd;
    logic [DIV_N-1:0]  int_dvd;
    logic [DIV_M-1:0]  ext_dsr;
    logic [DIV_M-1:0]  int_dsr;
    logic              ext_busy;
    logic              int_busy;
    logic [DIV_N-1:0]  ext_quo;
    logic [DIV_N-1:0]  int_quo;
    logic [VOLT_W-1:0] ext_mean;
    logic [VOLT_W-1:0] int_mean;
    logic [VOLT_W-1:0] cur;
    logic [VOLT_W+1:0] lo18;
    logic [VOLT_W+1:0] cur18;
    logic [VOLT_W+1:0] thr1;
    logic [VOLT_W+1:0] thr2;
    logic [VOLT_W+1:0] thr3;
    logic [9:0]        iv3;
    blm_ring_st_t      ring_st;

    assign tick_stall   = (state_reg != ST_IDLE);
    assign tick_acc     = tick_valid && !tick_stall;
    assign acting       = (tick_cnt_reg == TICK_W'(READ_PERIOD));
    assign good         = tick_acc && acting && tick.read_ok;
    assign fail_inc     = (fail_cnt_reg < FAIL_MAX) ? fail_cnt_reg + 1'b1 : fail_cnt_reg;

    assign ext_clamped  = clamp_volt(tick.ext_voltage, min_reg, max_reg);
    assign int_clamped  = clamp_volt(tick.int_voltage, min_reg, max_reg);
    assign ext_off      = ext_held_reg - min_reg;
    assign int_off      = int_held_reg - min_reg;
    assign range_bad    = (max_reg <= min_reg);

    assign span_neg     = (max_reg < min_reg);
    assign span_mag     = span_neg ? (min_reg - max_reg) : (max_reg - min_reg);
    assign span_prod    = PROD_W'(span_mag) * PROD_W'(LVL_RECIP);
    assign iv_mag       = span_prod[LVL_SHIFT +: 8];

    assign sweep_done   = ring_st.done && !ext_busy && !int_busy;
    assign mean_done    = !ext_busy && !int_busy;
    assign div_start    = good || ((state_reg == ST_SWEEP) && sweep_done);

    assign ext_mean     = (ring_st.ext_cnt == '0) ? '0 : ext_quo[VOLT_W-1:0];
    assign int_mean     = (ring_st.int_cnt == '0) ? '0 : int_quo[VOLT_W-1:0];

    assign cur          = drain_reg ? ext_held_reg : int_held_reg;
    assign cur18        = (VOLT_W + 2)'(cur);
    assign lo18         = (VOLT_W + 2)'(min_reg);
    assign iv3          = 10'({interval_reg, 1'b0}) + 10'(interval_reg);
    assign thr1         = lo18 + (VOLT_W + 2)'(interval_reg);
    assign thr2         = lo18 + (VOLT_W + 2)'({interval_reg, 1'b0});
    assign thr3         = lo18 + (VOLT_W + 2)'(iv3);

    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            ext_dvd = ring_st.ext_sum;
            int_dvd = ring_st.int_sum;
            ext_dsr = ring_st.ext_cnt;
            int_dsr = ring_st.int_cnt;
        end
        else
        begin
            ext_dvd = DIV_N'(ext_off) * DIV_N'(PCT_FULL);
            int_dvd = DIV_N'(int_off) * DIV_N'(PCT_FULL);
            ext_dsr = DIV_M'(max_reg - min_reg);
            int_dsr = DIV_M'(max_reg - min_reg);
        end
    end

    blm_ring #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (good),
        .ext_sample (ext_clamped),
        .int_sample (int_clamped),
        .status     (ring_st)
    );

    blm_div u_ext_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ext_dvd),
        .divisor  (ext_dsr),
        .busy     (ext_busy),
        .quotient (ext_quo)
    );

    blm_div u_int_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (int_dvd),
        .divisor  (int_dsr),
        .busy     (int_busy),
        .quotient (int_quo)
    );

    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        delta_next = delta_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_VOLTAGE: min_next   = cfg_data;
                CFG_MAX_VOLTAGE: max_next   = cfg_data;
                CFG_MAX_DELTA:   delta_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        tick_cnt_next     = tick_cnt_reg;
        fail_cnt_next     = fail_cnt_reg;
        present_next      = present_reg;
        level_next        = level_reg;
        ext_pct_next      = ext_pct_reg;
        int_pct_next      = int_pct_reg;
        ext_held_next     = ext_held_reg;
        int_held_next     = int_held_reg;
        upd_next          = upd_reg;
        drain_next        = drain_reg;
        supply_next       = supply_reg;
        interval_next     = interval_reg;
        ext_pz_next       = ext_pz_reg;
        int_pz_next       = int_pz_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    if (!acting)
                    begin
                        tick_cnt_next = tick_cnt_reg + 1'b1;
                        upd_next      = 1'b0;
                        state_next    = ST_EMIT;
                    end
                    else if (!tick.read_ok)
                    begin
                        tick_cnt_next = '0;
                        fail_cnt_next = fail_inc;
                        if (fail_inc > FAIL_LIMIT)
                        begin
                            present_next = 1'b0;
                        end
                        upd_next   = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        tick_cnt_next = '0;
                        fail_cnt_next = '0;
                        present_next  = 1'b1;
                        upd_next      = 1'b1;
                        drain_next    = tick.drain_external;
                        supply_next   = tick.on_supply;
                        interval_next = span_neg ? (~iv_mag + 8'd1) : iv_mag;
                        ext_pz_next   = range_bad || (ext_held_reg < min_reg);
                        int_pz_next   = range_bad || (int_held_reg < min_reg);
                        state_next    = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    ext_pct_next = pct_fix(ext_pz_reg, ext_quo);
                    int_pct_next = pct_fix(int_pz_reg, int_quo);
                    state_next   = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (mean_done)
                begin
                    ext_held_next = follow_mean(ext_held_reg, ext_mean, delta_reg);
                    int_held_next = follow_mean(int_held_reg, int_mean, delta_reg);
                    state_next    = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                if (supply_reg)
                begin
                    level_next = LVL_SUPPLY;
                end
                else if (cur18 <= lo18)
                begin
                    level_next = LVL_EMPTY;
                end
                else if (cur18 <= thr1)
                begin
                    level_next = LVL_LOW;
                end
                else if (cur18 <= thr2)
                begin
                    level_next = LVL_MID;
                end
                else if (cur18 <= thr3)
                begin
                    level_next = LVL_HIGH;
                end
                else
                begin
                    level_next = LVL_FULL;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.updated         = upd_reg;
                    result_next.level_code      = level_reg;
                    result_next.ext_percent     = ext_pct_reg;
                    result_next.int_percent     = int_pct_reg;
                    result_next.ext_level       = ext_held_reg;
                    result_next.int_level       = int_held_reg;
                    result_next.manager_present = present_reg;
                    result_valid_next           = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tick_cnt_reg     <= '0;
            fail_cnt_reg     <= '0;
            present_reg      <= 1'b0;
            level_reg        <= '0;
            ext_pct_reg      <= '0;
            int_pct_reg      <= '0;
            ext_held_reg     <= '0;
            int_held_reg     <= '0;
            min_reg          <= MIN_VOLTAGE_RST;
            max_reg          <= MAX_VOLTAGE_RST;
            delta_reg        <= MAX_DELTA_RST;
            upd_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_cnt_reg     <= tick_cnt_next;
            fail_cnt_reg     <= fail_cnt_next;
            present_reg      <= present_next;
            level_reg        <= level_next;
            ext_pct_reg      <= ext_pct_next;
            int_pct_reg      <= int_pct_next;
            ext_held_reg     <= ext_held_next;
            int_held_reg     <= int_held_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            delta_reg        <= delta_next;
            upd_reg          <= upd_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_reg    <= drain_next;
        supply_reg   <= supply_next;
        interval_reg <= interval_next;
        ext_pz_reg   <= ext_pz_next;
        int_pz_reg   <= int_pz_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

endmodule
